// ===== hw/rtl/pch_pkg.sv =====
// ----------------------------------------------------------------------------
// pch_pkg: shared types and constants for the pair correlation histogrammer
// Field widths, register indexes, register reset values and the control
// state encoding.
// ----------------------------------------------------------------------------
package pch_pkg;

    // Fixed field widths
    localparam int FIELD_W    = 16;
    localparam int CNT_W      = 32;
    localparam int READ_RAP_W = 6;
    localparam int READ_PHI_W = 5;
    localparam int CFG_IDX_W  = 3;

    // Rapidity difference is exact in 17 signed bits; bin = (rel * scale) >> 20
    localparam int RAP_DIFF_W = FIELD_W + 1;
    localparam int RAP_PROD_W = RAP_DIFF_W + FIELD_W;
    localparam int RBIN_SHIFT = 20;
    localparam int RBIN_W     = RAP_PROD_W - RBIN_SHIFT;

    // Opcodes
    localparam logic OP_BIN  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PT_MIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PT_MAX        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAP_MIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAP_BIN_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHI_OFFSET    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_SELF  = 3'd5;

    // Register reset values
    localparam logic [FIELD_W-1:0] PT_MIN_RST     = 16'd0;
    localparam logic [FIELD_W-1:0] PT_MAX_RST     = 16'hFFFF;
    localparam logic [FIELD_W-1:0] RAP_MIN_RST    = 16'hE000;  // -2.0 in Q3.12
    localparam logic [FIELD_W-1:0] RAP_SCALE_RST  = 16'd4096;  // 16 bins per unit
    localparam logic [FIELD_W-1:0] PHI_OFFSET_RST = 16'h4000;  // quarter turn

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Control sequence
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_ADDR,
        ST_READ,
        ST_WB
    } state_t;

endpackage

// ===== hw/rtl/pair_correlation_histogram.sv =====
// ----------------------------------------------------------------------------
// pair_correlation_histogram: two-particle correlation histogrammer
// Bins particle pairs by wrapped azimuth difference and rapidity difference
// into saturating 32-bit counters held in one RAM; read transactions return
// one counter.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    opcode, pt, phi, rap, tag, rotation,
//                                             read_rap_bin, read_phi_bin
//   m_        out        m_valid / m_ready    binned, count
//   cfg_      in         cfg_wr_en            cfg_addr, cfg_wr_data
//
// A transaction passes through accept and cuts, the two bin multiplies, the
// address multiply, the RAM read, then the read-modify-write back.
// The counter RAM has a single read-modify-write in flight, so no forwarding.
// After reset a clearing pass zeroes the RAM, with s_ready low throughout.
// A result waiting on m_ready sits in the output register while
// the next transaction is accepted; that one holds in write-back until the
// output register frees.
// ----------------------------------------------------------------------------
module pair_correlation_histogram
    import pch_pkg::*;
#(
    parameter int RAP_BINS = 64,
    parameter int PHI_BINS = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [FIELD_W-1:0]     cfg_wr_data,

    // Input transactions
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    input  logic [FIELD_W-1:0]     s_pt_first,
    input  logic [FIELD_W-1:0]     s_pt_second,
    input  logic [FIELD_W-1:0]     s_phi_first,
    input  logic [FIELD_W-1:0]     s_phi_second,
    input  logic signed [FIELD_W-1:0] s_rap_first,
    input  logic signed [FIELD_W-1:0] s_rap_second,
    input  logic [FIELD_W-1:0]     s_tag_first,
    input  logic [FIELD_W-1:0]     s_tag_second,
    input  logic [FIELD_W-1:0]     s_rotation,
    input  logic [READ_RAP_W-1:0]  s_read_rap_bin,
    input  logic [READ_PHI_W-1:0]  s_read_phi_bin,

    // Result transactions
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_binned,
    output logic [CNT_W-1:0]       m_count
);

    localparam int DEPTH      = RAP_BINS * PHI_BINS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int RAP_IDX_W  = $clog2(RAP_BINS);
    localparam int PHI_IDX_W  = $clog2(PHI_BINS);
    localparam int PHI_CNT_W  = $clog2(PHI_BINS + 1);
    localparam int PHI_PROD_W = FIELD_W + PHI_CNT_W;

    // Configuration registers
    logic [FIELD_W-1:0] pt_min_reg;
    logic [FIELD_W-1:0] pt_max_reg;
    logic [FIELD_W-1:0] rap_min_reg;
    logic [FIELD_W-1:0] rap_scale_reg;
    logic [FIELD_W-1:0] phi_offset_reg;
    logic               excl_self_reg;

    // Control
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               out_valid_reg, out_valid_next;

    // Transaction payload
    logic                  op_reg, op_next;
    logic                  keep_reg, keep_next;
    logic                  hit_reg, hit_next;
    logic [FIELD_W-1:0]    phi_reg, phi_next;
    logic [RAP_DIFF_W-1:0] rel_reg, rel_next;
    logic [READ_RAP_W-1:0] rd_rap_reg, rd_rap_next;
    logic [READ_PHI_W-1:0] rd_phi_reg, rd_phi_next;
    logic [RBIN_W-1:0]     rbin_reg, rbin_next;
    logic [PHI_IDX_W-1:0]  pbin_reg, pbin_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic                  binned_reg, binned_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    // Datapath terms
    logic                  pt_ok;
    logic                  self_pair;
    logic [RAP_DIFF_W-1:0] rap_diff;
    logic [RAP_DIFF_W:0]   rap_rel;
    logic [PHI_PROD_W-1:0] phi_prod;
    logic [RAP_PROD_W-1:0] rap_prod;
    logic                  read_in_range;

    // RAM port
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CNT_W-1:0]  ram_wr_data;
    logic [CNT_W-1:0]  ram_rd_data;

    // ------------------------------------------------------------------------
    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_min_reg     <= PT_MIN_RST;
            pt_max_reg     <= PT_MAX_RST;
            rap_min_reg    <= RAP_MIN_RST;
            rap_scale_reg  <= RAP_SCALE_RST;
            phi_offset_reg <= PHI_OFFSET_RST;
            excl_self_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_PT_MIN:        pt_min_reg     <= cfg_wr_data;
                CFG_PT_MAX:        pt_max_reg     <= cfg_wr_data;
                CFG_RAP_MIN:       rap_min_reg    <= cfg_wr_data;
                CFG_RAP_BIN_SCALE: rap_scale_reg  <= cfg_wr_data;
                CFG_PHI_OFFSET:    phi_offset_reg <= cfg_wr_data;
                CFG_EXCLUDE_SELF:  excl_self_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Cut terms on the incoming transaction
    assign pt_ok = (s_pt_first  >= pt_min_reg) && (s_pt_first  <= pt_max_reg) &&
                   (s_pt_second >= pt_min_reg) && (s_pt_second <= pt_max_reg);
    assign self_pair = excl_self_reg && (s_tag_first == s_tag_second);

    // Exact 17-bit rapidity difference, then offset by rap_min (18 bits signed)
    assign rap_diff = {s_rap_first[FIELD_W-1], s_rap_first} -
                      {s_rap_second[FIELD_W-1], s_rap_second};
    assign rap_rel  = {rap_diff[RAP_DIFF_W-1], rap_diff} -
                      {{2{rap_min_reg[FIELD_W-1]}}, rap_min_reg};

    // Bin multiplies on registered operands
    assign phi_prod = PHI_PROD_W'(phi_reg) * PHI_PROD_W'(PHI_BINS);
    assign rap_prod = RAP_PROD_W'(rel_reg) * RAP_PROD_W'(rap_scale_reg);

    assign read_in_range = (32'(rd_rap_reg) < 32'(RAP_BINS)) &&
                           (32'(rd_phi_reg) < 32'(PHI_BINS));

    // ------------------------------------------------------------------------
    // Next state, RAM control and payload
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        keep_next      = keep_reg;
        hit_next       = hit_reg;
        phi_next       = phi_reg;
        rel_next       = rel_reg;
        rd_rap_next    = rd_rap_reg;
        rd_phi_next    = rd_phi_reg;
        rbin_next      = rbin_reg;
        pbin_next      = pbin_reg;
        addr_next      = addr_reg;
        binned_next    = binned_reg;
        count_next     = count_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = addr_reg;
        ram_wr_data    = '0;

        // result leaves the output register
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_opcode;
                    keep_next   = pt_ok && !self_pair && !rap_rel[RAP_DIFF_W];
                    phi_next    = s_phi_first - s_phi_second + s_rotation + phi_offset_reg;
                    rel_next    = rap_rel[RAP_DIFF_W-1:0];
                    rd_rap_next = s_read_rap_bin;
                    rd_phi_next = s_read_phi_bin;
                    state_next  = ST_CALC;
                end
            end

            ST_CALC: begin
                if (op_reg == OP_READ) begin
                    rbin_next = RBIN_W'(rd_rap_reg);
                    pbin_next = PHI_IDX_W'(rd_phi_reg);
                    hit_next  = read_in_range;
                end else begin
                    rbin_next = rap_prod[RAP_PROD_W-1 -: RBIN_W];
                    pbin_next = phi_prod[FIELD_W +: PHI_IDX_W];
                    hit_next  = keep_reg &&
                                (rap_prod[RAP_PROD_W-1 -: RBIN_W] < RBIN_W'(RAP_BINS));
                end
                state_next = ST_ADDR;
            end

            ST_ADDR: begin
                addr_next  = ADDR_W'(rbin_reg[RAP_IDX_W-1:0]) * ADDR_W'(PHI_BINS) +
                             ADDR_W'(pbin_reg);
                state_next = ST_READ;
            end

            ST_READ: begin
                state_next = ST_WB;
            end

            ST_WB: begin
                // hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    binned_next    = (op_reg == OP_BIN) && hit_reg;
                    count_next     = ((op_reg == OP_READ) && hit_reg) ? ram_rd_data : '0;
                    ram_wr_en      = (op_reg == OP_BIN) && hit_reg;
                    ram_wr_data    = (ram_rd_data == CNT_MAX) ? ram_rd_data
                                                              : ram_rd_data + 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        keep_reg   <= keep_next;
        hit_reg    <= hit_next;
        phi_reg    <= phi_next;
        rel_reg    <= rel_next;
        rd_rap_reg <= rd_rap_next;
        rd_phi_reg <= rd_phi_next;
        rbin_reg   <= rbin_next;
        pbin_reg   <= pbin_next;
        addr_reg   <= addr_next;
        binned_reg <= binned_next;
        count_reg  <= count_next;
    end

    // ------------------------------------------------------------------------
    // Counter store
    pch_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_counts (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_binned = binned_reg;
    assign m_count  = count_reg;

`ifndef SYNTH
    // a binned pair never carries a count
    a_binned_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_binned |-> m_count == '0)
        else $error("binned result with nonzero count");

    // no transaction is taken while the clearing pass runs
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("input ready during clearing pass");

    // a full counter is written back unchanged
    a_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en && state_reg == ST_WB && ram_rd_data == CNT_MAX |->
        ram_wr_data == CNT_MAX)
        else $error("counter wrapped past full scale");

    // leaving write-back always presents a result
    a_wb_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WB && state_next == ST_IDLE |=> m_valid)
        else $error("write-back finished without a result");
`endif

endmodule

// ===== hw/rtl/pch_ram.sv =====
// ----------------------------------------------------------------------------
// pch_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1280
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== verif/pair_correlation_histogram_test.sv =====
// ----------------------------------------------------------------------------
// pair_correlation_histogram_test: self-checking bench for the pair histogrammer
// A short directed table covers reset state, field extremes, out-of-range
// reads, self-pair and momentum cuts, zero scale and the register extremes.
// Random phases follow, each with its own cut setting. A local histogram
// model predicts every result. Both channels idle at random but in steady phases.
// ----------------------------------------------------------------------------
module pair_correlation_histogram_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pch_pkg::*;

    localparam int RAP_BINS     = 64;
    localparam int PHI_BINS     = 20;
    localparam int CELLS        = RAP_BINS * PHI_BINS;
    localparam int MAX_GAP      = 12;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 65;

    typedef struct packed {
        logic                  opcode;
        logic [FIELD_W-1:0]    pt_first;
        logic [FIELD_W-1:0]    pt_second;
        logic [FIELD_W-1:0]    phi_first;
        logic [FIELD_W-1:0]    phi_second;
        logic [FIELD_W-1:0]    rap_first;
        logic [FIELD_W-1:0]    rap_second;
        logic [FIELD_W-1:0]    tag_first;
        logic [FIELD_W-1:0]    tag_second;
        logic [FIELD_W-1:0]    rotation;
        logic [READ_RAP_W-1:0] read_rap_bin;
        logic [READ_PHI_W-1:0] read_phi_bin;
    } pair_item_t;

    typedef struct packed {
        logic             binned;
        logic [CNT_W-1:0] count;
    } hist_result_t;

    // Cut and binning registers as held by the block
    typedef struct packed {
        logic [FIELD_W-1:0] pt_lo;
        logic [FIELD_W-1:0] pt_hi;
        logic [FIELD_W-1:0] rap_floor;
        logic [FIELD_W-1:0] rap_scale;
        logic [FIELD_W-1:0] phi_shift;
        logic               drop_self;
    } cuts_t;

    typedef enum logic {ROW_ITEM, ROW_CUTS} row_kind_e;

    typedef struct packed {
        row_kind_e    kind;
        pair_item_t   item;
        cuts_t        cuts;
        logic         typed;
        hist_result_t fixed_result;
    } stim_row_t;

    localparam cuts_t RESET_CUTS = '{pt_lo: PT_MIN_RST, pt_hi: PT_MAX_RST,
                                     rap_floor: RAP_MIN_RST, rap_scale: RAP_SCALE_RST,
                                     phi_shift: PHI_OFFSET_RST, drop_self: 1'b0};

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr       = '0;
    logic [FIELD_W-1:0]     cfg_wr_data    = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic                   s_opcode       = 1'b0;
    logic [FIELD_W-1:0]     s_pt_first     = '0;
    logic [FIELD_W-1:0]     s_pt_second    = '0;
    logic [FIELD_W-1:0]     s_phi_first    = '0;
    logic [FIELD_W-1:0]     s_phi_second   = '0;
    logic signed [FIELD_W-1:0] s_rap_first  = '0;
    logic signed [FIELD_W-1:0] s_rap_second = '0;
    logic [FIELD_W-1:0]     s_tag_first    = '0;
    logic [FIELD_W-1:0]     s_tag_second   = '0;
    logic [FIELD_W-1:0]     s_rotation     = '0;
    logic [READ_RAP_W-1:0]  s_read_rap_bin = '0;
    logic [READ_PHI_W-1:0]  s_read_phi_bin = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic                   m_binned;
    logic [CNT_W-1:0]       m_count;

    pair_correlation_histogram #(
        .RAP_BINS (RAP_BINS),
        .PHI_BINS (PHI_BINS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_pt_first     (s_pt_first),
        .s_pt_second    (s_pt_second),
        .s_phi_first    (s_phi_first),
        .s_phi_second   (s_phi_second),
        .s_rap_first    (s_rap_first),
        .s_rap_second   (s_rap_second),
        .s_tag_first    (s_tag_first),
        .s_tag_second   (s_tag_second),
        .s_rotation     (s_rotation),
        .s_read_rap_bin (s_read_rap_bin),
        .s_read_phi_bin (s_read_phi_bin),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_binned       (m_binned),
        .m_count        (m_count)
    );

    always #5 aclk = ~aclk;

    // Histogram model state
    logic [CNT_W-1:0] cell_counts [CELLS];
    cuts_t            active_cuts;
    int               last_hit_rap;
    int               last_hit_phi;

    hist_result_t expected_results[$];
    int  fail_count      = 0;
    int  pairs_sent      = 0;
    int  reads_sent      = 0;
    int  binned_seen     = 0;
    int  settings_loaded = 0;
    int  cycle_count     = 0;
    bit  steady          = 1'b0;

    // Run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Histogram model: applies one transaction, returns its result
    function automatic hist_result_t predict_histogram(input pair_item_t it);
        hist_result_t      r;
        logic [FIELD_W-1:0] a;
        int unsigned       pbin;
        int                y1;
        int                y2;
        int                d;
        int                floor_v;
        longint unsigned   rbin;
        int unsigned       slot;
        r = '0;
        if (it.opcode == OP_READ) begin
            if (it.read_rap_bin < RAP_BINS && it.read_phi_bin < PHI_BINS)
                r.count = cell_counts[it.read_rap_bin * PHI_BINS + it.read_phi_bin];
            return r;
        end
        if (it.pt_first < active_cuts.pt_lo || it.pt_first > active_cuts.pt_hi ||
            it.pt_second < active_cuts.pt_lo || it.pt_second > active_cuts.pt_hi)
            return r;
        if (active_cuts.drop_self && it.tag_first == it.tag_second)
            return r;
        // wrapped azimuth difference, then bin by fraction of a turn
        a = it.phi_first - it.phi_second + it.rotation + active_cuts.phi_shift;
        pbin = (32'(a) * PHI_BINS) >> 16;
        y1 = $signed(it.rap_first);
        y2 = $signed(it.rap_second);
        d = y1 - y2;
        floor_v = $signed(active_cuts.rap_floor);
        if (d < floor_v)
            return r;
        rbin = (longint'(d - floor_v) * active_cuts.rap_scale) >> RBIN_SHIFT;
        if (rbin >= RAP_BINS || pbin >= PHI_BINS)
            return r;
        slot = int'(rbin) * PHI_BINS + pbin;
        if (cell_counts[slot] != CNT_MAX)
            cell_counts[slot] = cell_counts[slot] + 1;
        last_hit_rap = int'(rbin);
        last_hit_phi = pbin;
        r.binned = 1'b1;
        return r;
    endfunction

    // Directed table row builders
    function automatic stim_row_t bin_row(input logic [15:0] ptf, pts, phf, phs, yf, ys,
                                          tf, ts, rot);
        stim_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item.opcode = OP_BIN;
        row.item.pt_first = ptf;
        row.item.pt_second = pts;
        row.item.phi_first = phf;
        row.item.phi_second = phs;
        row.item.rap_first = yf;
        row.item.rap_second = ys;
        row.item.tag_first = tf;
        row.item.tag_second = ts;
        row.item.rotation = rot;
        row.item.read_rap_bin = '1;
        row.item.read_phi_bin = '1;
        return row;
    endfunction

    function automatic stim_row_t read_row(input int rr, input int rp);
        stim_row_t row;
        row = bin_row('1, '1, '1, '1, '1, '1, '1, '1, '1);
        row.item.opcode = OP_READ;
        row.item.read_rap_bin = READ_RAP_W'(rr);
        row.item.read_phi_bin = READ_PHI_W'(rp);
        return row;
    endfunction

    function automatic stim_row_t cuts_row(input cuts_t c);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CUTS;
        row.cuts = c;
        return row;
    endfunction

    function automatic stim_row_t typed_as(input stim_row_t row, input logic b,
                                           input logic [CNT_W-1:0] cnt);
        stim_row_t r;
        r = row;
        r.typed = 1'b1;
        r.fixed_result.binned = b;
        r.fixed_result.count = cnt;
        return r;
    endfunction

    // One input transaction: random gap, present, wait for the handshake
    task automatic drive_item(input pair_item_t it, input logic typed,
                              input hist_result_t fixed_result);
        int           gap;
        bit           taken;
        hist_result_t r;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= it.opcode;
        s_pt_first     <= it.pt_first;
        s_pt_second    <= it.pt_second;
        s_phi_first    <= it.phi_first;
        s_phi_second   <= it.phi_second;
        s_rap_first    <= it.rap_first;
        s_rap_second   <= it.rap_second;
        s_tag_first    <= it.tag_first;
        s_tag_second   <= it.tag_second;
        s_rotation     <= it.rotation;
        s_read_rap_bin <= it.read_rap_bin;
        s_read_phi_bin <= it.read_phi_bin;
        do begin
            @(negedge aclk);
            taken = (s_ready === 1'b1);
            @(posedge aclk);
        end while (!taken);
        r = predict_histogram(it);
        if (typed)
            r = fixed_result;
        expected_results.push_back(r);
        if (it.opcode == OP_READ)
            reads_sent++;
        else
            pairs_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
    endtask

    // Reprogram all registers once the block has drained
    task automatic load_cuts(input cuts_t c);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(CFG_PT_MIN, c.pt_lo);
        write_reg(CFG_PT_MAX, c.pt_hi);
        write_reg(CFG_RAP_MIN, c.rap_floor);
        write_reg(CFG_RAP_BIN_SCALE, c.rap_scale);
        write_reg(CFG_PHI_OFFSET, c.phi_shift);
        write_reg(CFG_EXCLUDE_SELF, {{(FIELD_W-1){1'b0}}, c.drop_self});
        cfg_wr_en <= 1'b0;
        active_cuts = c;
        settings_loaded++;
    endtask

    // Result side: random stalls, compare against oldest expectation
    initial begin
        int           stall;
        bit           got;
        hist_result_t act;
        hist_result_t exp_r;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                got = (m_valid === 1'b1);
                act.binned = m_binned;
                act.count = m_count;
                @(posedge aclk);
            end while (!got);
            if (expected_results.size() == 0) begin
                $error("result with nothing pending: binned=%0d count=%0d",
                       act.binned, act.count);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (act.binned !== exp_r.binned) begin
                    $error("binned mismatch: expected %0d, actual %0d",
                           exp_r.binned, act.binned);
                    fail_count++;
                end
                if (act.count !== exp_r.count) begin
                    $error("count mismatch: expected %0d, actual %0d",
                           exp_r.count, act.count);
                    fail_count++;
                end
                if (act.binned === 1'b1)
                    binned_seen++;
            end
        end
    end

    // Stimulus
    initial begin
        stim_row_t  directed[$];
        cuts_t      c;
        pair_item_t it;
        pair_item_t prev_pair;
        bit         have_prev;
        int         roll;
        int         floor_v;
        int         span;
        int         d;
        int         lo_y;
        int         hi_y;
        int         y2;

        for (int i = 0; i < CELLS; i++)
            cell_counts[i] = '0;
        active_cuts = RESET_CUTS;
        last_hit_rap = 0;
        last_hit_phi = 0;
        have_prev = 1'b0;
        prev_pair = '0;

        // reset state and out-of-range reads
        directed.push_back(typed_as(read_row(0, 0), 1'b0, '0));
        directed.push_back(typed_as(read_row(RAP_BINS - 1, PHI_BINS - 1), 1'b0, '0));
        directed.push_back(typed_as(read_row(5, PHI_BINS), 1'b0, '0));
        directed.push_back(typed_as(read_row(RAP_BINS - 1, 31), 1'b0, '0));
        // momentum extremes, same cell twice, then read it back
        directed.push_back(bin_row(16'h0000, 16'hFFFF, 0, 0, 0, 0, 7, 7, 0));
        directed.push_back(bin_row(16'h0000, 16'hFFFF, 0, 0, 0, 0, 7, 7, 0));
        directed.push_back(read_row(32, 5));
        // rapidity difference at both ends of its range
        directed.push_back(bin_row(100, 200, 16'hFFFF, 0, 16'h7FFF, 16'h8000, 1, 2, 16'hFFFF));
        directed.push_back(bin_row(100, 200, 0, 16'hFFFF, 16'h8000, 16'h7FFF, 1, 2, 0));
        directed.push_back(bin_row(300, 400, 16'h8000, 16'h1000, 16'h1000, 0, 3, 4, 16'h2000));
        // self-pair exclusion
        c = RESET_CUTS;
        c.drop_self = 1'b1;
        directed.push_back(cuts_row(c));
        directed.push_back(typed_as(bin_row(50, 60, 0, 0, 0, 0, 16'hABCD, 16'hABCD, 0),
                                    1'b0, '0));
        directed.push_back(bin_row(50, 60, 0, 0, 0, 0, 16'h0000, 16'hFFFF, 0));
        // empty momentum window
        c = RESET_CUTS;
        c.pt_lo = 16'd1000;
        c.pt_hi = 16'd999;
        directed.push_back(cuts_row(c));
        directed.push_back(typed_as(bin_row(1000, 999, 0, 0, 0, 0, 1, 2, 0), 1'b0, '0));
        directed.push_back(typed_as(bin_row(999, 1000, 0, 0, 0, 0, 1, 2, 0), 1'b0, '0));
        // single-value window, lowest rapidity floor, zero scale
        c = '{pt_lo: 16'd500, pt_hi: 16'd500, rap_floor: 16'h8000, rap_scale: 16'h0000,
              phi_shift: 16'h0000, drop_self: 1'b0};
        directed.push_back(cuts_row(c));
        directed.push_back(bin_row(500, 500, 16'h3333, 0, 16'h7FFF, 16'h8000, 5, 5, 0));
        directed.push_back(bin_row(499, 500, 16'h3333, 0, 0, 0, 5, 6, 0));
        directed.push_back(read_row(0, 3));
        // highest floor, scale and offset
        c = '{pt_lo: 16'h0000, pt_hi: 16'hFFFF, rap_floor: 16'h7FFF, rap_scale: 16'hFFFF,
              phi_shift: 16'hFFFF, drop_self: 1'b1};
        directed.push_back(cuts_row(c));
        directed.push_back(bin_row(0, 16'hFFFF, 1, 0, 16'h7FFF, 16'h0000, 1, 2, 0));
        directed.push_back(bin_row(0, 16'hFFFF, 1, 0, 16'h7FFF, 16'hFFFF, 1, 2, 0));
        directed.push_back(read_row(0, 0));
        directed.push_back(cuts_row(RESET_CUTS));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CUTS)
                load_cuts(directed[i].cuts);
            else
                drive_item(directed[i].item, directed[i].typed, directed[i].fixed_result);
        end

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: c = RESET_CUTS;
                1: c = '{pt_lo: 16'h0000, pt_hi: 16'hFFFF, rap_floor: 16'h8000,
                         rap_scale: 16'hFFFF, phi_shift: 16'hFFFF, drop_self: 1'b1};
                2: c = '{pt_lo: 16'h0000, pt_hi: 16'h0000, rap_floor: 16'h8000,
                         rap_scale: 16'h0000, phi_shift: 16'h0000, drop_self: 1'b0};
                default: begin
                    c.pt_lo = 16'($urandom_range(0, 3000));
                    c.pt_hi = 16'($urandom_range(20000, 65535));
                    if ($urandom_range(0, 7) == 0) begin
                        c.pt_lo = 16'($urandom_range(1, 65535));
                        c.pt_hi = 16'($urandom_range(0, c.pt_lo - 1));
                    end
                    c.rap_floor = 16'($urandom());
                    c.rap_scale = 16'($urandom());
                    c.phi_shift = 16'($urandom());
                    c.drop_self = 1'($urandom_range(0, 1));
                end
            endcase
            load_cuts(c);
            steady = (phase % 4 == 3);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                it.opcode       = OP_BIN;
                it.pt_first     = 16'($urandom());
                it.pt_second    = 16'($urandom());
                it.phi_first    = 16'($urandom());
                it.phi_second   = 16'($urandom());
                it.rap_first    = 16'($urandom());
                it.rap_second   = 16'($urandom());
                it.tag_first    = 16'($urandom());
                it.tag_second   = 16'($urandom());
                it.rotation     = 16'($urandom());
                it.read_rap_bin = READ_RAP_W'($urandom());
                it.read_phi_bin = READ_PHI_W'($urandom());
                roll = $urandom_range(0, 99);
                if (roll < 30) begin
                    // read, often of the cell hit last
                    it.opcode = OP_READ;
                    if ($urandom_range(0, 1) == 1) begin
                        it.read_rap_bin = READ_RAP_W'(last_hit_rap);
                        it.read_phi_bin = READ_PHI_W'(last_hit_phi);
                    end else if ($urandom_range(0, 9) != 0) begin
                        it.read_phi_bin = READ_PHI_W'($urandom_range(0, PHI_BINS - 1));
                    end
                end else if (roll < 45) begin
                    // noise: fully random pair
                end else if (roll < 60 && have_prev) begin
                    it = prev_pair;
                end else begin
                    // well-formed pair aimed inside the current window
                    if (active_cuts.pt_lo <= active_cuts.pt_hi) begin
                        it.pt_first  = 16'($urandom_range(active_cuts.pt_lo, active_cuts.pt_hi));
                        it.pt_second = 16'($urandom_range(active_cuts.pt_lo, active_cuts.pt_hi));
                    end
                    if ($urandom_range(0, 3) == 0)
                        it.tag_second = it.tag_first;
                    if ($urandom_range(0, 1) == 1)
                        it.rotation = '0;
                    floor_v = $signed(active_cuts.rap_floor);
                    span = (active_cuts.rap_scale == 0) ? 65535 :
                           ((RAP_BINS << RBIN_SHIFT) - 1) / active_cuts.rap_scale;
                    if (span > 65535 - floor_v)
                        span = 65535 - floor_v;
                    d = floor_v + $urandom_range(0, span);
                    lo_y = (d > 0) ? -32768 : -32768 - d;
                    hi_y = (d > 0) ? 32767 - d : 32767;
                    y2 = lo_y + $urandom_range(0, hi_y - lo_y);
                    it.rap_second = 16'(y2);
                    it.rap_first  = 16'(y2 + d);
                end
                if (it.opcode == OP_BIN) begin
                    prev_pair = it;
                    have_prev = 1'b1;
                end
                drive_item(it, 1'b0, '0);
            end
        end

        // Drain and settle
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d pair and %0d read transactions under %0d register settings.",
                 pairs_sent, reads_sent, settings_loaded);
        $display("%0d pairs landed in a bin.", binned_seen);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
